/* rtl/pdws_pkg.sv */
package pdws_pkg;

    localparam int SMOOTH_WEIGHT = 10;
    localparam int ACCUM_BITS    = 48;
    localparam int RANGE_BITS    = 16;

    localparam int SMOOTH_W    = 24;
    localparam int SMOOTH_DIV  = SMOOTH_WEIGHT + 1;
    localparam int DIV_LOG     = $clog2(SMOOTH_DIV);
    localparam int NUM_W       = SMOOTH_W + DIV_LOG;
    localparam int RECIP_SHIFT = NUM_W + DIV_LOG;
    localparam int PROD_W      = NUM_W + RECIP_SHIFT;
    localparam longint unsigned RECIP_MUL =
        ((64'd1 << RECIP_SHIFT) + SMOOTH_WEIGHT) / SMOOTH_DIV;
    localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 24'd15360;

    localparam int ERR_W     = 33;
    localparam int DERR_W    = 34;
    localparam int ESUM_LO_W = ACCUM_BITS / 2;
    localparam int ESUM_HI_W = ACCUM_BITS - ESUM_LO_W;
    localparam int PP_W      = ERR_W + 33;
    localparam int PD_W      = DERR_W + 33;
    localparam int PL_W      = ESUM_LO_W + 34;
    localparam int PH_W      = ESUM_HI_W + 33;
    localparam int SUM_W     = ACCUM_BITS + 34;
    localparam int SH_W      = SUM_W - 16;
    localparam int CORR_W    = 32;
    localparam int ROUND_HALF = 32768;
    localparam longint CORR_LIMIT = 64'sd1 <<< 30;
    localparam logic signed [SH_W-1:0] CORR_POS = SH_W'(CORR_LIMIT);
    localparam logic signed [SH_W-1:0] CORR_NEG = -CORR_POS;

    localparam int DRIVE_SUM = 30;
    localparam logic [9:0] DUTY_CENTER = 10'd76;
    localparam logic [9:0] DUTY_FAR    = 10'd115;
    localparam logic [9:0] DUTY_CLOSE  = 10'd38;

    localparam int APB_ADDR_W = 5;

    typedef enum logic [1:0] {
        STEER_CENTER = 2'd0,
        STEER_FAR    = 2'd1,
        STEER_CLOSE  = 2'd2
    } steer_t;

    typedef enum logic [2:0] {
        REG_KP            = 3'd0,
        REG_KI            = 3'd1,
        REG_KD_OVER_DT    = 3'd2,
        REG_BASE_SPEED    = 3'd3,
        REG_WALL_TARGET   = 3'd4,
        REG_WALL_DEADBAND = 3'd5,
        REG_DRIVE_MIN     = 3'd6,
        REG_DRIVE_MAX     = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] kp;
        logic [31:0] ki;
        logic [31:0] kd_over_dt;
        logic [4:0]  base_speed;
        logic [15:0] wall_target;
        logic [15:0] wall_deadband;
        logic [7:0]  drive_min;
        logic [7:0]  drive_max;
    } cfg_t;

    typedef struct packed {
        logic [SMOOTH_W-1:0]          smoothed;
        logic signed [ERR_W-1:0]      err;
        logic signed [DERR_W-1:0]     derr;
        logic signed [ACCUM_BITS-1:0] esum;
    } track_t;

    typedef struct packed {
        logic [SMOOTH_W-1:0]      smoothed;
        logic signed [CORR_W-1:0] corr;
    } corr_t;

endpackage

/* rtl/pdws_cfg_regs.sv */
module pdws_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pdws_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output pdws_pkg::cfg_t                   cfg
);

    pdws_pkg::cfg_t   cfg_reg;
    pdws_pkg::reg_idx_t idx;
    logic             wr_en;

    assign pready = 1'b1;
    assign idx    = pdws_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp            <= 32'd167772;
            cfg_reg.ki            <= 32'd13422;
            cfg_reg.kd_over_dt    <= 32'd168;
            cfg_reg.base_speed    <= 5'd17;
            cfg_reg.wall_target   <= 16'd60;
            cfg_reg.wall_deadband <= 16'd5;
            cfg_reg.drive_min     <= 8'd12;
            cfg_reg.drive_max     <= 8'd18;
        end else if (wr_en) begin
            unique case (idx)
                pdws_pkg::REG_KP:            cfg_reg.kp            <= pwdata;
                pdws_pkg::REG_KI:            cfg_reg.ki            <= pwdata;
                pdws_pkg::REG_KD_OVER_DT:    cfg_reg.kd_over_dt    <= pwdata;
                pdws_pkg::REG_BASE_SPEED:    cfg_reg.base_speed    <= pwdata[4:0];
                pdws_pkg::REG_WALL_TARGET:   cfg_reg.wall_target   <= pwdata[15:0];
                pdws_pkg::REG_WALL_DEADBAND: cfg_reg.wall_deadband <= pwdata[15:0];
                pdws_pkg::REG_DRIVE_MIN:     cfg_reg.drive_min     <= pwdata[7:0];
                pdws_pkg::REG_DRIVE_MAX:     cfg_reg.drive_max     <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            pdws_pkg::REG_KP:            prdata = cfg_reg.kp;
            pdws_pkg::REG_KI:            prdata = cfg_reg.ki;
            pdws_pkg::REG_KD_OVER_DT:    prdata = cfg_reg.kd_over_dt;
            pdws_pkg::REG_BASE_SPEED:    prdata = {27'd0, cfg_reg.base_speed};
            pdws_pkg::REG_WALL_TARGET:   prdata = {16'd0, cfg_reg.wall_target};
            pdws_pkg::REG_WALL_DEADBAND: prdata = {16'd0, cfg_reg.wall_deadband};
            pdws_pkg::REG_DRIVE_MIN:     prdata = {24'd0, cfg_reg.drive_min};
            pdws_pkg::REG_DRIVE_MAX:     prdata = {24'd0, cfg_reg.drive_max};
        endcase
    end

endmodule

/* rtl/pdws_track.sv */
module pdws_track (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [15:0]          range_reading,
    input  logic signed [31:0]   left_count,
    input  logic signed [31:0]   right_count,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pdws_pkg::track_t     out_data
);

    logic                                   valid_reg;
    pdws_pkg::track_t                       data_reg;
    logic [pdws_pkg::SMOOTH_W-1:0]          smooth_reg;
    logic [pdws_pkg::SMOOTH_W-1:0]          smooth_next;
    logic signed [pdws_pkg::ACCUM_BITS-1:0] esum_reg;
    logic signed [pdws_pkg::ACCUM_BITS-1:0] esum_next;
    logic signed [pdws_pkg::ERR_W-1:0]      last_err_reg;
    logic signed [pdws_pkg::ERR_W-1:0]      err;
    logic signed [pdws_pkg::DERR_W-1:0]     derr;
    logic signed [pdws_pkg::ACCUM_BITS:0]   esum_wide;
    logic [pdws_pkg::RANGE_BITS-1:0]        reading;
    logic [pdws_pkg::NUM_W-1:0]             num;
    logic [pdws_pkg::PROD_W-1:0]            prod;
    logic                                   take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        reading = range_reading[pdws_pkg::RANGE_BITS-1:0];
        // Weighted average, divided by the weight plus one through a reciprocal multiply.
        num = pdws_pkg::NUM_W'({reading, 8'd0})
            + pdws_pkg::NUM_W'(pdws_pkg::SMOOTH_WEIGHT) * pdws_pkg::NUM_W'(smooth_reg);
        prod = pdws_pkg::PROD_W'(num) * pdws_pkg::PROD_W'(pdws_pkg::RECIP_MUL);
        smooth_next = (reading != '0)
            ? prod[pdws_pkg::RECIP_SHIFT +: pdws_pkg::SMOOTH_W] : smooth_reg;

        err  = pdws_pkg::ERR_W'(left_count) + pdws_pkg::ERR_W'(right_count);
        derr = pdws_pkg::DERR_W'(err) - pdws_pkg::DERR_W'(last_err_reg);

        esum_wide = (pdws_pkg::ACCUM_BITS + 1)'(esum_reg)
                  + (pdws_pkg::ACCUM_BITS + 1)'(err);
        if (esum_wide[pdws_pkg::ACCUM_BITS] != esum_wide[pdws_pkg::ACCUM_BITS-1]) begin
            esum_next = esum_wide[pdws_pkg::ACCUM_BITS]
                ? {1'b1, {(pdws_pkg::ACCUM_BITS-1){1'b0}}}
                : {1'b0, {(pdws_pkg::ACCUM_BITS-1){1'b1}}};
        end else begin
            esum_next = esum_wide[pdws_pkg::ACCUM_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            smooth_reg   <= pdws_pkg::SMOOTH_RESET;
            esum_reg     <= '0;
            last_err_reg <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (take) begin
                smooth_reg   <= smooth_next;
                esum_reg     <= esum_next;
                last_err_reg <= err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg.smoothed <= smooth_next;
            data_reg.err      <= err;
            data_reg.derr     <= derr;
            data_reg.esum     <= esum_next;
        end
    end

endmodule

/* rtl/pdws_pid_math.sv */
module pdws_pid_math (
    input  logic             aclk,
    input  logic             aresetn,
    input  pdws_pkg::cfg_t   cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  pdws_pkg::track_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pdws_pkg::corr_t  out_data
);

    logic v2_reg, v3_reg, v4_reg;
    logic rdy2, rdy3, rdy4;

    logic signed [pdws_pkg::PP_W-1:0]  s2_pp_reg, s2_pp_next;
    logic signed [pdws_pkg::PD_W-1:0]  s2_pd_reg, s2_pd_next;
    logic signed [pdws_pkg::PL_W-1:0]  s2_pl_reg, s2_pl_next;
    logic signed [pdws_pkg::PH_W-1:0]  s2_ph_reg, s2_ph_next;
    logic [pdws_pkg::SMOOTH_W-1:0]     s2_smooth_reg;

    logic signed [pdws_pkg::SUM_W-1:0] s3_iprod_reg, s3_iprod_next;
    logic signed [pdws_pkg::SUM_W-1:0] s3_pdsum_reg, s3_pdsum_next;
    logic [pdws_pkg::SMOOTH_W-1:0]     s3_smooth_reg;

    logic signed [pdws_pkg::SUM_W-1:0] total;
    logic signed [pdws_pkg::SH_W-1:0]  shifted;
    logic signed [pdws_pkg::SH_W-1:0]  clamped;
    pdws_pkg::corr_t                   s4_reg, s4_next;

    assign rdy4      = !v4_reg || out_ready;
    assign rdy3      = !v3_reg || rdy4;
    assign rdy2      = !v2_reg || rdy3;
    assign in_ready  = rdy2;
    assign out_valid = v4_reg;
    assign out_data  = s4_reg;

    always_comb begin
        s2_pp_next = pdws_pkg::PP_W'(in_data.err)
                   * pdws_pkg::PP_W'($signed({1'b0, cfg.kp}));
        s2_pd_next = pdws_pkg::PD_W'(in_data.derr)
                   * pdws_pkg::PD_W'($signed({1'b0, cfg.kd_over_dt}));
        // The integral product is split into a low and a high partial product.
        s2_pl_next = pdws_pkg::PL_W'($signed({1'b0, in_data.esum[pdws_pkg::ESUM_LO_W-1:0]}))
                   * pdws_pkg::PL_W'($signed({1'b0, cfg.ki}));
        s2_ph_next = pdws_pkg::PH_W'($signed(
                         in_data.esum[pdws_pkg::ACCUM_BITS-1:pdws_pkg::ESUM_LO_W]))
                   * pdws_pkg::PH_W'($signed({1'b0, cfg.ki}));

        s3_iprod_next = (pdws_pkg::SUM_W'(s2_ph_reg) <<< pdws_pkg::ESUM_LO_W)
                      + pdws_pkg::SUM_W'(s2_pl_reg);
        s3_pdsum_next = pdws_pkg::SUM_W'(s2_pp_reg) + pdws_pkg::SUM_W'(s2_pd_reg);

        total   = s3_iprod_reg + s3_pdsum_reg + pdws_pkg::SUM_W'(pdws_pkg::ROUND_HALF);
        shifted = $signed(total[pdws_pkg::SUM_W-1:16]);
        if (shifted > pdws_pkg::CORR_POS) begin
            clamped = pdws_pkg::CORR_POS;
        end else if (shifted < pdws_pkg::CORR_NEG) begin
            clamped = pdws_pkg::CORR_NEG;
        end else begin
            clamped = shifted;
        end
        s4_next.smoothed = s3_smooth_reg;
        s4_next.corr     = $signed(clamped[pdws_pkg::CORR_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy2) v2_reg <= in_valid;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && in_valid) begin
            s2_pp_reg     <= s2_pp_next;
            s2_pd_reg     <= s2_pd_next;
            s2_pl_reg     <= s2_pl_next;
            s2_ph_reg     <= s2_ph_next;
            s2_smooth_reg <= in_data.smoothed;
        end
        if (rdy3 && v2_reg) begin
            s3_iprod_reg  <= s3_iprod_next;
            s3_pdsum_reg  <= s3_pdsum_next;
            s3_smooth_reg <= s2_smooth_reg;
        end
        if (rdy4 && v3_reg) begin
            s4_reg <= s4_next;
        end
    end

endmodule

/* rtl/pdws_out.sv */
module pdws_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  pdws_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  pdws_pkg::corr_t in_data,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [47:0]     m_tdata
);

    logic                  valid_reg;
    logic [47:0]           data_reg, data_next;
    logic signed [25:0]    diff;
    logic [25:0]           mag;
    logic [17:0]           werr_mag;
    logic signed [18:0]    werr;
    logic signed [18:0]    band;
    pdws_pkg::steer_t      choice;
    logic [9:0]            duty;
    logic signed [6:0]     base_first;
    logic signed [6:0]     base_second;
    logic [7:0]            drive_first;
    logic [7:0]            drive_second;

    function automatic logic [7:0] drive_calc(input logic signed [6:0]  base,
                                              input logic signed [31:0] corr,
                                              input logic [7:0]         dmin,
                                              input logic [7:0]         dmax);
        logic signed [33:0] x;
        logic signed [33:0] lo;
        logic signed [33:0] hi;
        logic [33:0]        r;
        x  = ($signed(34'(base)) <<< 8) - 34'(corr);
        lo = $signed({18'd0, dmin, 8'd0});
        hi = $signed({18'd0, dmax, 8'd0});
        if (x < lo) x = lo;
        if (x > hi) x = hi;
        r = $unsigned(x) + 34'd128;
        return r[15:8];
    endfunction

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_comb begin
        diff     = $signed({2'b00, in_data.smoothed}) - $signed({2'b00, cfg.wall_target, 8'd0});
        mag      = diff[25] ? $unsigned(-diff) : $unsigned(diff);
        werr_mag = mag[25:8];
        werr     = diff[25] ? -$signed({1'b0, werr_mag}) : $signed({1'b0, werr_mag});
        band     = $signed({3'b000, cfg.wall_deadband});
        if (werr > band) begin
            choice = pdws_pkg::STEER_FAR;
            duty   = pdws_pkg::DUTY_FAR;
        end else if (werr < -band) begin
            choice = pdws_pkg::STEER_CLOSE;
            duty   = pdws_pkg::DUTY_CLOSE;
        end else begin
            choice = pdws_pkg::STEER_CENTER;
            duty   = pdws_pkg::DUTY_CENTER;
        end

        base_first   = 7'(pdws_pkg::DRIVE_SUM) - $signed({2'b00, cfg.base_speed});
        base_second  = $signed({2'b00, cfg.base_speed});
        drive_first  = drive_calc(base_first, in_data.corr, cfg.drive_min, cfg.drive_max);
        drive_second = drive_calc(base_second, in_data.corr, cfg.drive_min, cfg.drive_max);

        data_next = {4'd0, in_data.smoothed[23:8], drive_second, drive_first, duty,
                     choice};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/pid_drive_and_wall_steer_top.sv */
// Channel   Direction  tdata layout (low bit first)                         Handshake
// s_        in         range_reading[15:0] left_count[47:16] right_count[79:48] tvalid/tready
// m_        out        steer_choice[1:0] steer_duty[11:2] first_drive[19:12]     tvalid/tready
//                      second_drive[27:20] filtered_range[43:28] zero[47:44]
// APB       in/out     8 registers at byte address 4*i, pready tied high
//
// One item is accepted per cycle while no stall on m_ backs up the pipeline; results leave m_ in order.
// Each item passes the tracking stage, three arithmetic stages and the output register.
// Every stage holds its item while the next one is full and stalled, so bubbles close up under stalls.
// Reset is synchronous and active low; it restores the registers and the filter state.
module pid_drive_and_wall_steer_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [79:0]                     s_tdata,  // range_reading, left_count, right_count
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,  // steer_choice, steer_duty, first_drive,
                                                      // second_drive, filtered_range, zero pad
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pdws_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    pdws_pkg::cfg_t   cfg;
    pdws_pkg::track_t track_data;
    pdws_pkg::corr_t  corr_data;
    logic             track_valid, track_ready;
    logic             corr_valid, corr_ready;

    pdws_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdws_track u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .range_reading (s_tdata[15:0]),
        .left_count    ($signed(s_tdata[47:16])),
        .right_count   ($signed(s_tdata[79:48])),
        .out_valid     (track_valid),
        .out_ready     (track_ready),
        .out_data      (track_data)
    );

    pdws_pid_math u_pid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (track_valid),
        .in_ready  (track_ready),
        .in_data   (track_data),
        .out_valid (corr_valid),
        .out_ready (corr_ready),
        .out_data  (corr_data)
    );

    pdws_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (corr_valid),
        .in_ready (corr_ready),
        .in_data  (corr_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
